// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/ppe_pkg.sv =====
// ----------------------------------------------------------------------------
// ppe_pkg
// Widths, codes, reset values and colour conversion for the pixel expander.
// ----------------------------------------------------------------------------
package ppe_pkg;

	// Transaction field widths
	localparam int OPCODE_W   = 2;
	localparam int PAL_IDX_W  = 8;
	localparam int RGB_W      = 24;
	localparam int WORD_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int RUN_LEN_W  = 11;
	localparam int CNT_W      = 4;
	localparam int POS_W      = 3;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_PAL_WRITE  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_RUN_START  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_PIXEL_DATA = 2'd2;

	// Source formats
	localparam logic [1:0] FMT_1BPP  = 2'd0;
	localparam logic [1:0] FMT_4BPP  = 2'd1;
	localparam logic [1:0] FMT_8BPP  = 2'd2;
	localparam logic [1:0] FMT_16BPP = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MONO_ZERO    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MONO_ONE     = 3'd4;

	// Register reset values
	localparam logic [1:0]        RST_PIXEL_FORMAT = FMT_8BPP;
	localparam logic [WORD_W-1:0] RST_MONO_ZERO    = 16'h0000;
	localparam logic [WORD_W-1:0] RST_MONO_ONE     = 16'hFFFF;

	// RGB888 to RGB565 by truncation
	function automatic logic [WORD_W-1:0] to565(input logic [RGB_W-1:0] c);
		return {c[23:19], c[15:10], c[7:3]};
	endfunction

endpackage

// ===== src/ppe_cmd_if.sv =====
// ----------------------------------------------------------------------------
// ppe_cmd_if
// Command channel: palette writes, run starts and source pixel data.
// ----------------------------------------------------------------------------
interface ppe_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [ppe_pkg::OPCODE_W-1:0]   opcode;
	logic [ppe_pkg::PAL_IDX_W-1:0]  palette_index;
	logic [ppe_pkg::RGB_W-1:0]      palette_rgb;
	logic [ppe_pkg::WORD_W-1:0]     src_word;

	modport source (output valid, opcode, palette_index, palette_rgb, src_word, input ready);
	modport sink (input valid, opcode, palette_index, palette_rgb, src_word, output ready);
endinterface

// ===== src/ppe_pix_if.sv =====
// ----------------------------------------------------------------------------
// ppe_pix_if
// Pixel channel: one RGB565 display word per transaction.
// ----------------------------------------------------------------------------
interface ppe_pix_if;
	logic                       valid;
	logic                       ready;
	logic [ppe_pkg::WORD_W-1:0] pixel_565;
	logic                       item_last;
	logic                       run_done;

	modport source (output valid, pixel_565, item_last, run_done, input ready);
	modport sink (input valid, pixel_565, item_last, run_done, output ready);
endinterface

// ===== src/palette_pixel_expander.sv =====
// ----------------------------------------------------------------------------
// palette_pixel_expander
// Expands 1/4/8 bpp palette or 16 bpp native source data into RGB565 words.
// ----------------------------------------------------------------------------
// Each pixel data transaction yields its pixels one per cycle on the pixel
// channel while the output is not stalled: a 1 bpp byte yields up to 8 pixels,
// a 4 bpp byte 1 or 2, 8 and 16 bpp one; the rate is set by the pixel
// sequencer, which issues one pixel and at most one palette read per cycle,
// unless the output is stalled, on the single read port of the palette RAM
// (registered read, result held in the output register). Palette writes, run
// starts and items past the end of a run are accepted when the sequencer is
// idle or in the cycle it issues its last pixel, so a palette write never
// overtakes an earlier lookup. The palette RAM has no reset; entries must be written before they are looked up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module palette_pixel_expander #(
	parameter int PALETTE_DEPTH = 256,
	parameter int RUN_MAX       = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ppe_cmd_if.sink                         cmd,
	ppe_pix_if.source                       pix,
	input  logic                            cfg_we,
	input  logic [ppe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ppe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int LEFT_W = $clog2(RUN_MAX + 1);
	localparam int CMP_W  = (LEFT_W > ppe_pkg::RUN_LEN_W) ? LEFT_W : ppe_pkg::RUN_LEN_W;
	localparam logic [ppe_pkg::PAL_IDX_W:0] PAL_LIM = (ppe_pkg::PAL_IDX_W + 1)'(PALETTE_DEPTH);

	// Configuration registers
	logic [1:0]                     fmt_q;
	logic [ppe_pkg::POS_W-1:0]      offs_q;
	logic [ppe_pkg::RUN_LEN_W-1:0]  run_len_q;
	logic [ppe_pkg::WORD_W-1:0]     mono0_q;
	logic [ppe_pkg::WORD_W-1:0]     mono1_q;

	// Run state
	logic [LEFT_W-1:0]              left_q;
	logic                           first_q;

	// Accept side
	logic                           cmd_acc;
	logic                           load_a;
	logic                           pal_we;
	logic [ppe_pkg::POS_W-1:0]      offs_a;
	logic [ppe_pkg::POS_W-1:0]      pos_a;
	logic [ppe_pkg::CNT_W-1:0]      c_a;
	logic [ppe_pkg::CNT_W-1:0]      n_a;
	logic [LEFT_W-1:0]              left_next_a;
	logic [LEFT_W-1:0]              run_len_sat;

	// Sequencer stage
	logic                           v_s1;
	logic [1:0]                     fmt_s1;
	logic [ppe_pkg::BYTE_W-1:0]     byte_s1;
	logic [ppe_pkg::WORD_W-1:0]     word_s1;
	logic [ppe_pkg::POS_W-1:0]      pos_s1;
	logic [ppe_pkg::CNT_W-1:0]      cnt_s1;
	logic                           end_s1;

	// Issue logic
	logic                           s2_adv;
	logic                           issue;
	logic                           last_issue;
	logic [ppe_pkg::PAL_IDX_W-1:0]  idx_i;
	logic                           bit_i;
	logic                           is_pal_i;
	logic                           oob_i;
	logic [ppe_pkg::WORD_W-1:0]     direct_i;
	logic                           rd_en;
	logic [PAL_AW-1:0]              rd_addr;

	// Output stage
	logic                           v_s2;
	logic                           pal_s2;
	logic                           zero_s2;
	logic [ppe_pkg::WORD_W-1:0]     direct_s2;
	logic                           last_s2;
	logic                           done_s2;
	logic [ppe_pkg::RGB_W-1:0]      rd_data_s2;

	// Palette RAM
	logic [ppe_pkg::RGB_W-1:0]      pal_mem [PALETTE_DEPTH];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q     <= ppe_pkg::RST_PIXEL_FORMAT;
			offs_q    <= '0;
			run_len_q <= '0;
			mono0_q   <= ppe_pkg::RST_MONO_ZERO;
			mono1_q   <= ppe_pkg::RST_MONO_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppe_pkg::REG_PIXEL_FORMAT: fmt_q     <= cfg_wdata[1:0];
				ppe_pkg::REG_START_OFFSET: offs_q    <= cfg_wdata[ppe_pkg::POS_W-1:0];
				ppe_pkg::REG_RUN_LENGTH:   run_len_q <= cfg_wdata[ppe_pkg::RUN_LEN_W-1:0];
				ppe_pkg::REG_MONO_ZERO:    mono0_q   <= cfg_wdata;
				ppe_pkg::REG_MONO_ONE:     mono1_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Accept: decode and pixel count for this transaction
	assign cmd_acc = cmd.valid && cmd.ready;
	assign offs_a  = first_q ? offs_q : '0;

	always_comb begin
		case (fmt_q)
			ppe_pkg::FMT_1BPP: begin
				c_a   = 4'd8 - {1'b0, offs_a};
				pos_a = offs_a;
			end
			ppe_pkg::FMT_4BPP: begin
				c_a   = offs_a[0] ? 4'd1 : 4'd2;
				pos_a = {2'b00, offs_a[0]};
			end
			default: begin
				c_a   = 4'd1;
				pos_a = '0;
			end
		endcase
	end

	assign n_a         = (left_q < LEFT_W'(c_a)) ? ppe_pkg::CNT_W'(left_q) : c_a;
	assign left_next_a = left_q - LEFT_W'(n_a);
	assign load_a      = cmd_acc && (cmd.opcode == ppe_pkg::OP_PIXEL_DATA) && (left_q != '0);
	assign run_len_sat = (CMP_W'(run_len_q) > CMP_W'(RUN_MAX)) ? LEFT_W'(RUN_MAX)
	                                                           : LEFT_W'(run_len_q);
	assign pal_we      = cmd_acc && (cmd.opcode == ppe_pkg::OP_PAL_WRITE) &&
	                     ({1'b0, cmd.palette_index} < PAL_LIM);

	// Run count and first-byte flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			first_q <= 1'b0;
		end else if (cmd_acc && (cmd.opcode == ppe_pkg::OP_RUN_START)) begin
			left_q  <= run_len_sat;
			first_q <= 1'b1;
		end else if (load_a) begin
			left_q  <= left_next_a;
			first_q <= 1'b0;
		end
	end

	// Sequencer handshake
	assign s2_adv     = !v_s2 || pix.ready;
	assign issue      = v_s1 && s2_adv;
	assign last_issue = issue && (cnt_s1 == 4'd1);
	assign cmd.ready  = !v_s1 || last_issue;

	// Sequencer: one pixel per issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_a) begin
			v_s1 <= 1'b1;
		end else if (last_issue) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_a) begin
			fmt_s1  <= fmt_q;
			byte_s1 <= cmd.src_word[ppe_pkg::BYTE_W-1:0];
			word_s1 <= cmd.src_word;
			pos_s1  <= pos_a;
			cnt_s1  <= n_a;
			end_s1  <= (left_next_a == '0);
		end else if (issue) begin
			pos_s1  <= pos_s1 + 3'd1;
			cnt_s1  <= cnt_s1 - 4'd1;
		end
	end

	// Pixel selection and palette address
	always_comb begin
		idx_i    = (fmt_s1 == ppe_pkg::FMT_4BPP) ?
		           {4'b0000, (pos_s1[0] ? byte_s1[3:0] : byte_s1[7:4])} : byte_s1;
		bit_i    = byte_s1[3'd7 - pos_s1];
		is_pal_i = (fmt_s1 == ppe_pkg::FMT_4BPP) || (fmt_s1 == ppe_pkg::FMT_8BPP);
		oob_i    = ({1'b0, idx_i} >= PAL_LIM);
		direct_i = (fmt_s1 == ppe_pkg::FMT_1BPP) ? (bit_i ? mono1_q : mono0_q) : word_s1;
		rd_en    = issue && is_pal_i && !oob_i;
		rd_addr  = PAL_AW'(idx_i);
	end

	// Palette RAM: write at accept, registered read at issue
	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[PAL_AW'(cmd.palette_index)] <= cmd.palette_rgb;
		end
		if (rd_en) begin
			rd_data_s2 <= pal_mem[rd_addr];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_adv) begin
			v_s2 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pal_s2    <= is_pal_i;
			zero_s2   <= oob_i;
			direct_s2 <= direct_i;
			last_s2   <= (cnt_s1 == 4'd1);
			done_s2   <= (cnt_s1 == 4'd1) && end_s1;
		end
	end

	assign pix.valid     = v_s2;
	assign pix.pixel_565 = pal_s2 ? (zero_s2 ? '0 : ppe_pkg::to565(rd_data_s2)) : direct_s2;
	assign pix.item_last = last_s2;
	assign pix.run_done  = done_s2;

	// Checks
	`ASSERT_ALWAYS(a_cnt_live, clk, arst_n, v_s1 |-> (cnt_s1 != 4'd0), "sequencer holds an empty item")
	`ASSERT_ALWAYS(a_done_last, clk, arst_n, (v_s2 && done_s2) |-> last_s2, "run end not on last pixel")
	`ASSERT_NEXT(a_rd_hold, clk, arst_n, (v_s2 && !pix.ready), $stable(rd_data_s2), "read data lost on stall")
	`ASSERT_ALWAYS(a_rd_fmt, clk, arst_n, rd_en |-> (fmt_s1 == ppe_pkg::FMT_4BPP || fmt_s1 == ppe_pkg::FMT_8BPP), "palette read in direct format")

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for palette_pixel_expander: a directed table followed
// by random phases of palette writes, run starts and pixel data, with every
// display word compared against a local expansion of the source stream or a word given in the table.
// ----------------------------------------------------------------------------
module testbench;

	localparam int                           RUN_MAX       = 1024;
	localparam logic [ppe_pkg::OPCODE_W-1:0] OP_RESERVED   = 2'd3;
	localparam int                           SETTLE_CYCLES = 16;
	localparam int                           END_CYCLES    = 40;
	localparam int                           PHASE_ITEMS   = 35;
	localparam int                           CYCLE_LIMIT   = 300000;

	typedef struct packed {
		logic [ppe_pkg::OPCODE_W-1:0]  opcode;
		logic [ppe_pkg::PAL_IDX_W-1:0] pal_idx;
		logic [ppe_pkg::RGB_W-1:0]     rgb;
		logic [ppe_pkg::WORD_W-1:0]    word;
	} src_cmd_t;

	typedef struct packed {
		logic [ppe_pkg::WORD_W-1:0] pix;
		logic                       last;
		logic                       done;
	} disp_word_t;

	// How the words of one command transaction are expected
	typedef enum logic [1:0] {CHECK_MODEL, CHECK_QUIET, CHECK_ONE} check_t;
	typedef enum logic {ROW_REG, ROW_CMD} row_t;

	typedef struct {
		row_t                           kind;
		logic [ppe_pkg::CFG_IDX_W-1:0]  reg_idx;
		logic [ppe_pkg::CFG_DATA_W-1:0] reg_val;
		src_cmd_t                       cmd;
		check_t                         check;
		disp_word_t                     want;
	} dir_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [ppe_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ppe_pkg::CFG_DATA_W-1:0] cfg_wdata;

	ppe_cmd_if cmd_bus();
	ppe_pix_if pix_bus();

	palette_pixel_expander i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_bus),
		.pix       (pix_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow of the registers and of the expander state
	logic [1:0]                    fmt_r    = ppe_pkg::RST_PIXEL_FORMAT;
	logic [ppe_pkg::POS_W-1:0]     offs_r   = '0;
	logic [ppe_pkg::RUN_LEN_W-1:0] run_r    = '0;
	logic [ppe_pkg::WORD_W-1:0]    mono0_r  = ppe_pkg::RST_MONO_ZERO;
	logic [ppe_pkg::WORD_W-1:0]    mono1_r  = ppe_pkg::RST_MONO_ONE;
	logic [ppe_pkg::RGB_W-1:0]     pal_mirror [256];
	logic [ppe_pkg::RUN_LEN_W-1:0] px_left  = '0;
	bit                            first_pending = 1'b0;

	// Stimulus side: which palette entries may be looked up
	bit                   pal_written [256];
	logic [7:0]           all_written [$];
	logic [3:0]           lo_written  [$];

	disp_word_t           fresh_pixels   [$];
	disp_word_t           pending_pixels [$];
	check_t               check_modes    [$];
	disp_word_t           typed_words    [$];

	bit                   calm = 1'b0;
	int                   fault_count = 0;
	int                   cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[palette_pixel_expander] ERROR");
			$finish;
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		pix_bus.ready <= calm || ($urandom_range(0, 99) >= 29);
	end

	task automatic report_fault(input string text);
		fault_count++;
		$display("%0t: %s", $time, text);
	endtask

	// ------------------------------------------------------------------
	// Expansion of one command into display words
	// ------------------------------------------------------------------
	function automatic logic [ppe_pkg::WORD_W-1:0] pal_lookup(input logic [7:0] idx);
		logic [ppe_pkg::RGB_W-1:0] e;
		e = pal_mirror[idx];
		return {e[23:19], e[15:10], e[7:3]};
	endfunction

	function automatic void push_pixel(input logic [ppe_pkg::WORD_W-1:0] p);
		if (px_left == 0 || fresh_pixels.size() >= 8)
			return;
		px_left = px_left - 1'b1;
		fresh_pixels.push_back('{pix: p, last: 1'b0, done: (px_left == 0)});
	endfunction

	function automatic void expand_item(input src_cmd_t c);
		logic [7:0] b;
		int         offs;
		fresh_pixels.delete();
		b = c.word[7:0];
		case (c.opcode)
			ppe_pkg::OP_PAL_WRITE: pal_mirror[c.pal_idx] = c.rgb;
			ppe_pkg::OP_RUN_START: begin
				px_left = (run_r > RUN_MAX) ? ppe_pkg::RUN_LEN_W'(RUN_MAX) : run_r;
				first_pending = 1'b1;
			end
			ppe_pkg::OP_PIXEL_DATA: if (px_left != 0) begin
				offs = first_pending ? int'(offs_r) : 0;
				first_pending = 1'b0;
				case (fmt_r)
					ppe_pkg::FMT_1BPP: begin
						// most significant bit first
						for (int pos = offs; pos < 8; pos++)
							push_pixel(b[7 - pos] ? mono1_r : mono0_r);
					end
					ppe_pkg::FMT_4BPP: begin
						// an odd offset skips the high nibble
						if ((offs % 2) == 0)
							push_pixel(pal_lookup({4'h0, b[7:4]}));
						push_pixel(pal_lookup({4'h0, b[3:0]}));
					end
					ppe_pkg::FMT_8BPP: push_pixel(pal_lookup(b));
					default: push_pixel(c.word);
				endcase
				if (fresh_pixels.size() > 0)
					fresh_pixels[$].last = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Monitor: command transactions feed the expected words, pixel
	// transactions are checked against the oldest one
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch
		check_t     mode;
		disp_word_t typed;
		disp_word_t want;
		src_cmd_t   seen;
		if (arst_n) begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				mode  = check_modes.pop_front();
				typed = typed_words.pop_front();
				seen  = '{cmd_bus.opcode, cmd_bus.palette_index, cmd_bus.palette_rgb,
					cmd_bus.src_word};
				expand_item(seen);
				case (mode)
					CHECK_MODEL: foreach (fresh_pixels[k]) pending_pixels.push_back(fresh_pixels[k]);
					CHECK_ONE:   pending_pixels.push_back(typed);
					default:     ;
				endcase
			end
			if (pix_bus.valid && pix_bus.ready) begin
				if (pending_pixels.size() == 0) begin
					report_fault($sformatf("unexpected pixel %h", pix_bus.pixel_565));
				end else begin
					want = pending_pixels.pop_front();
					if (pix_bus.pixel_565 !== want.pix)
						report_fault($sformatf("pixel_565 %h, want %h",
							pix_bus.pixel_565, want.pix));
					if (pix_bus.item_last !== want.last)
						report_fault($sformatf("item_last %b, want %b (pixel %h)",
							pix_bus.item_last, want.last, want.pix));
					if (pix_bus.run_done !== want.done)
						report_fault($sformatf("run_done %b, want %b (pixel %h)",
							pix_bus.run_done, want.done, want.pix));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	task automatic drive_cmd(input src_cmd_t c, input check_t m, input disp_word_t w);
		cfg_we <= 1'b0;
		while (!calm && $urandom_range(0, 99) < 29) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		if (c.opcode == ppe_pkg::OP_PAL_WRITE && !pal_written[c.pal_idx]) begin
			pal_written[c.pal_idx] = 1'b1;
			all_written.push_back(c.pal_idx);
			if (c.pal_idx < 16)
				lo_written.push_back(c.pal_idx[3:0]);
		end
		check_modes.push_back(m);
		typed_words.push_back(w);
		cmd_bus.valid         <= 1'b1;
		cmd_bus.opcode        <= c.opcode;
		cmd_bus.palette_index <= c.pal_idx;
		cmd_bus.palette_rgb   <= c.rgb;
		cmd_bus.src_word      <= c.word;
		do @(posedge clk); while (!cmd_bus.ready);
	endtask

	// Hold the sender until every expected word is out, then idle for the padding given by pad
	task automatic drain(input int pad);
		cmd_bus.valid <= 1'b0;
		cfg_we        <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
		repeat (pad) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ppe_pkg::CFG_IDX_W-1:0] idx,
			input logic [ppe_pkg::CFG_DATA_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		case (idx)
			ppe_pkg::REG_PIXEL_FORMAT: fmt_r   = v[1:0];
			ppe_pkg::REG_START_OFFSET: offs_r  = v[ppe_pkg::POS_W-1:0];
			ppe_pkg::REG_RUN_LENGTH:   run_r   = v[ppe_pkg::RUN_LEN_W-1:0];
			ppe_pkg::REG_MONO_ZERO:    mono0_r = v;
			ppe_pkg::REG_MONO_ONE:     mono1_r = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic dir_row_t reg_row(input logic [ppe_pkg::CFG_IDX_W-1:0] idx,
			input logic [ppe_pkg::CFG_DATA_W-1:0] v);
		dir_row_t r;
		r = '{kind: ROW_REG, reg_idx: idx, reg_val: v, cmd: '0, check: CHECK_QUIET, want: '0};
		return r;
	endfunction

	function automatic dir_row_t cmd_row(input logic [ppe_pkg::OPCODE_W-1:0] op,
			input logic [7:0] idx, input logic [ppe_pkg::RGB_W-1:0] rgb,
			input logic [ppe_pkg::WORD_W-1:0] word, input check_t chk,
			input logic [ppe_pkg::WORD_W-1:0] pix = '0, input logic last = 1'b0,
			input logic done = 1'b0);
		dir_row_t r;
		r = '{kind: ROW_CMD, reg_idx: '0, reg_val: '0, cmd: '{op, idx, rgb, word},
			check: chk, want: '{pix, last, done}};
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		dir_row_t                   rows [$];
		src_cmd_t                   c;
		logic [ppe_pkg::WORD_W-1:0] v;
		int                         r;
		bit                         busy;

		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_index             <= '0;
		cfg_wdata             <= '0;
		cmd_bus.valid         <= 1'b0;
		cmd_bus.opcode        <= '0;
		cmd_bus.palette_index <= '0;
		cmd_bus.palette_rgb   <= '0;
		cmd_bus.src_word      <= '0;
		busy = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table: palette set-up, zero run, reserved opcode, then each format
		rows.push_back(cmd_row(ppe_pkg::OP_PAL_WRITE, 8'd0, 24'hFFFFFF, 16'h0000, CHECK_QUIET));
		rows.push_back(cmd_row(ppe_pkg::OP_PAL_WRITE, 8'd255, 24'hF80000, 16'hFFFF, CHECK_QUIET));
		rows.push_back(cmd_row(ppe_pkg::OP_PAL_WRITE, 8'd15, 24'h00FC00, 16'h0000, CHECK_QUIET));
		rows.push_back(cmd_row(ppe_pkg::OP_PAL_WRITE, 8'd1, 24'h0000F8, 16'h0000, CHECK_QUIET));
		rows.push_back(cmd_row(ppe_pkg::OP_PAL_WRITE, 8'd2, 24'h070307, 16'h0000, CHECK_QUIET));
		rows.push_back(cmd_row(ppe_pkg::OP_PIXEL_DATA, 8'd0, 24'h0, 16'h0000, CHECK_QUIET));
		rows.push_back(cmd_row(OP_RESERVED, 8'hFF, 24'hFFFFFF, 16'hFFFF, CHECK_QUIET));
		rows.push_back(reg_row(ppe_pkg::REG_RUN_LENGTH, 16'd3));
		rows.push_back(cmd_row(ppe_pkg::OP_RUN_START, 8'd0, 24'h0, 16'h0000, CHECK_QUIET));
		rows.push_back(cmd_row(ppe_pkg::OP_PIXEL_DATA, 8'd0, 24'h0, 16'hAB00, CHECK_ONE,
			16'hFFFF, 1'b1, 1'b0));
		rows.push_back(cmd_row(ppe_pkg::OP_PIXEL_DATA, 8'd0, 24'h0, 16'h00FF, CHECK_ONE,
			16'hF800, 1'b1, 1'b0));
		rows.push_back(cmd_row(ppe_pkg::OP_PIXEL_DATA, 8'd0, 24'h0, 16'h0002, CHECK_ONE,
			16'h0000, 1'b1, 1'b1));
		rows.push_back(cmd_row(ppe_pkg::OP_PIXEL_DATA, 8'd0, 24'h0, 16'h0001, CHECK_QUIET));
		rows.push_back(reg_row(ppe_pkg::REG_PIXEL_FORMAT, 16'(ppe_pkg::FMT_16BPP)));
		rows.push_back(reg_row(ppe_pkg::REG_RUN_LENGTH, 16'd2));
		rows.push_back(cmd_row(ppe_pkg::OP_RUN_START, 8'd0, 24'h0, 16'h0000, CHECK_QUIET));
		rows.push_back(cmd_row(ppe_pkg::OP_PIXEL_DATA, 8'd0, 24'h0, 16'hFFFF, CHECK_ONE,
			16'hFFFF, 1'b1, 1'b0));
		rows.push_back(cmd_row(ppe_pkg::OP_PIXEL_DATA, 8'd0, 24'h0, 16'h0000, CHECK_ONE,
			16'h0000, 1'b1, 1'b1));
		rows.push_back(reg_row(ppe_pkg::REG_PIXEL_FORMAT, 16'(ppe_pkg::FMT_4BPP)));
		rows.push_back(reg_row(ppe_pkg::REG_START_OFFSET, 16'd1));
		rows.push_back(reg_row(ppe_pkg::REG_RUN_LENGTH, 16'd4));
		rows.push_back(cmd_row(ppe_pkg::OP_RUN_START, 8'd0, 24'h0, 16'h0000, CHECK_QUIET));
		rows.push_back(cmd_row(ppe_pkg::OP_PIXEL_DATA, 8'd0, 24'h0, 16'h00F1, CHECK_ONE,
			16'h001F, 1'b1, 1'b0));
		rows.push_back(cmd_row(ppe_pkg::OP_PIXEL_DATA, 8'd0, 24'h0, 16'h0F0F, CHECK_MODEL));
		rows.push_back(reg_row(ppe_pkg::REG_START_OFFSET, 16'd6));
		rows.push_back(cmd_row(ppe_pkg::OP_RUN_START, 8'd0, 24'h0, 16'h0000, CHECK_QUIET));
		rows.push_back(cmd_row(ppe_pkg::OP_PIXEL_DATA, 8'd0, 24'h0, 16'h001F, CHECK_MODEL));
		rows.push_back(reg_row(ppe_pkg::REG_PIXEL_FORMAT, 16'(ppe_pkg::FMT_1BPP)));
		rows.push_back(reg_row(ppe_pkg::REG_START_OFFSET, 16'd7));
		rows.push_back(reg_row(ppe_pkg::REG_MONO_ZERO, 16'h1234));
		rows.push_back(reg_row(ppe_pkg::REG_MONO_ONE, 16'h8001));
		rows.push_back(reg_row(ppe_pkg::REG_RUN_LENGTH, 16'd20));
		rows.push_back(cmd_row(ppe_pkg::OP_RUN_START, 8'd0, 24'h0, 16'h0000, CHECK_QUIET));
		rows.push_back(cmd_row(ppe_pkg::OP_PIXEL_DATA, 8'd0, 24'h0, 16'hFE01, CHECK_ONE,
			16'h8001, 1'b1, 1'b0));
		rows.push_back(cmd_row(ppe_pkg::OP_PIXEL_DATA, 8'd0, 24'h0, 16'h00A5, CHECK_MODEL));
		rows.push_back(reg_row(ppe_pkg::REG_RUN_LENGTH, 16'd2047));
		rows.push_back(cmd_row(ppe_pkg::OP_RUN_START, 8'd0, 24'h0, 16'h0000, CHECK_QUIET));
		rows.push_back(cmd_row(ppe_pkg::OP_PIXEL_DATA, 8'd0, 24'h0, 16'h003C, CHECK_MODEL));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_REG) begin
				if (busy) begin
					drain(SETTLE_CYCLES);
					busy = 1'b0;
				end
				write_reg(rows[i].reg_idx, rows[i].reg_val);
			end else begin
				drive_cmd(rows[i].cmd, rows[i].check, rows[i].want);
				busy = 1'b1;
			end
		end

		// Random phases, each with its own register setting
		for (int ph = 0; ph < 9; ph++) begin
			drain(SETTLE_CYCLES);
			calm = (ph == 4);
			v = 16'($urandom);
			v[1:0] = 2'(ph % 4);
			write_reg(ppe_pkg::REG_PIXEL_FORMAT, v);
			v = 16'($urandom);
			v[2:0] = (ph == 0) ? 3'd0 : (ph == 1) ? 3'd7 : 3'($urandom_range(0, 7));
			write_reg(ppe_pkg::REG_START_OFFSET, v);
			v = 16'($urandom);
			if (ph == 2)
				v[10:0] = 11'd1024;
			else if ($urandom_range(0, 9) == 0)
				v[10:0] = 11'd0;
			else
				v[10:0] = 11'($urandom_range(1, 24));
			write_reg(ppe_pkg::REG_RUN_LENGTH, v);
			write_reg(ppe_pkg::REG_MONO_ZERO,
				(ph == 3) ? 16'h0000 : (ph == 5) ? 16'hFFFF : 16'($urandom));
			write_reg(ppe_pkg::REG_MONO_ONE,
				(ph == 3) ? 16'hFFFF : (ph == 5) ? 16'h0000 : 16'($urandom));

			// most phases open a fresh run, the rest carry on with the old count
			if ($urandom_range(0, 9) < 7)
				drive_cmd('{ppe_pkg::OP_RUN_START, 8'($urandom), 24'($urandom),
					16'($urandom)}, CHECK_MODEL, '0);

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 6 && k == 20)
					drain(0);
				r = $urandom_range(0, 99);
				c.opcode  = ppe_pkg::OP_PIXEL_DATA;
				c.pal_idx = 8'($urandom);
				c.rgb     = 24'($urandom);
				c.word    = 16'($urandom);
				if (r < 8) begin
					c.opcode = ppe_pkg::OP_PAL_WRITE;
					if ($urandom_range(0, 1))
						c.pal_idx = 8'($urandom_range(0, 15));
				end else if (r < 15) begin
					c.opcode = ppe_pkg::OP_RUN_START;
				end else if (r < 18) begin
					c.opcode = OP_RESERVED;
				end else if (fmt_r == ppe_pkg::FMT_4BPP) begin
					// both nibbles must name written entries
					c.word[7:4] = lo_written[$urandom_range(0, lo_written.size() - 1)];
					c.word[3:0] = lo_written[$urandom_range(0, lo_written.size() - 1)];
				end else if (fmt_r == ppe_pkg::FMT_8BPP && !pal_written[c.word[7:0]]) begin
					c.word[7:0] = all_written[$urandom_range(0, all_written.size() - 1)];
				end
				drive_cmd(c, CHECK_MODEL, '0);
			end
		end

		// Oversized run length: the count saturates, run_done on pixel 1024
		drain(SETTLE_CYCLES);
		write_reg(ppe_pkg::REG_PIXEL_FORMAT, 16'(ppe_pkg::FMT_1BPP));
		write_reg(ppe_pkg::REG_START_OFFSET, 16'd0);
		write_reg(ppe_pkg::REG_RUN_LENGTH, 16'd2047);
		calm = 1'b1;
		drive_cmd('{ppe_pkg::OP_RUN_START, 8'h00, 24'h0, 16'h0000}, CHECK_MODEL, '0);
		for (int k = 0; k < 130; k++)
			drive_cmd('{ppe_pkg::OP_PIXEL_DATA, 8'($urandom), 24'($urandom), 16'($urandom)},
				CHECK_MODEL, '0);
		calm = 1'b0;

		drain(END_CYCLES);
		if (fault_count == 0)
			$display("[palette_pixel_expander] OK");
		else
			$display("[palette_pixel_expander] ERROR");
		$finish;
	end

endmodule
